/* design/sync_length_xor_frame_parser_assert.svh */
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLXFP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SLXFP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/slxfp_pkg.sv */
package slxfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;
    localparam int STORE_DEPTH     = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int StoreAw = $clog2(STORE_DEPTH);
    localparam int CountW  = $clog2(STORE_DEPTH + 1);

    localparam logic [7:0] SYNC_FIRST  = 8'h06;
    localparam logic [7:0] SYNC_SECOND = 8'h85;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CHK_ERR = 2'd1;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        command;
        logic [CountW-1:0] count;
    } t_frame_desc;

    typedef struct packed {
        logic               en;
        logic [StoreAw-1:0] addr;
        logic [7:0]         data;
    } t_store_wr;

    typedef struct packed {
        logic q_full;
        logic pending;
    } t_drain_status;

endpackage

/* design/slxfp_front.sv */
module slxfp_front #(
    parameter int MAX_PAYLOAD = slxfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rx_valid,
    output logic                      o_rx_ready,
    input  logic [7:0]                i_rx_byte,
    input  slxfp_pkg::t_drain_status  i_drain,
    output logic                      o_push,
    output slxfp_pkg::t_frame_desc    o_desc,
    output slxfp_pkg::t_store_wr      o_wr
);

    localparam int Capacity = (MAX_PAYLOAD < 1) ? 1 :
        ((MAX_PAYLOAD > slxfp_pkg::STORE_DEPTH) ? slxfp_pkg::STORE_DEPTH : MAX_PAYLOAD);
    localparam int CountW = slxfp_pkg::CountW;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHECK = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic [7:0]        r_len, n_len;
    logic [CountW-1:0] r_seen, n_seen;
    logic [7:0]        r_check, n_check;
    logic [7:0]        r_cmd, n_cmd;
    logic              accept;
    logic [CountW-1:0] seen_inc;
    logic [7:0]        len_m1;

    always_comb begin
        unique case (r_phase)
            PH_DATA:          o_rx_ready = !i_drain.pending;
            PH_LEN, PH_CHECK: o_rx_ready = !i_drain.q_full;
            default:          o_rx_ready = 1'b1;
        endcase
    end

    assign accept   = i_rx_valid && o_rx_ready;
    assign seen_inc = r_seen + CountW'(1);
    assign len_m1   = r_len - 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        n_check = r_check;
        n_cmd   = r_cmd;
        o_push  = 1'b0;
        o_desc  = '{status: slxfp_pkg::STATUS_OK, command: r_cmd, count: len_m1[CountW-1:0]};
        o_wr    = '{en: 1'b0, addr: r_seen[slxfp_pkg::StoreAw-1:0], data: i_rx_byte};
        if (accept) begin
            unique case (r_phase)
                PH_SYNC2: begin
                    if (i_rx_byte == slxfp_pkg::SYNC_SECOND) begin
                        n_phase = PH_LEN;
                    end else if (i_rx_byte == slxfp_pkg::SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte == 8'd0) begin
                        n_phase = PH_SYNC1;
                    end else if ({1'b0, i_rx_byte} > 9'(Capacity + 1)) begin
                        n_phase = PH_SYNC1;
                        o_push  = 1'b1;
                        o_desc  = '{status: slxfp_pkg::STATUS_LEN_ERR, command: 8'd0,
                                    count: '0};
                    end else begin
                        n_len   = i_rx_byte;
                        n_check = i_rx_byte;
                        n_seen  = '0;
                        n_phase = PH_CMD;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_check = r_check ^ i_rx_byte;
                    n_phase = (r_len > 8'd1) ? PH_DATA : PH_CHECK;
                end
                PH_DATA: begin
                    o_wr.en = 1'b1;
                    n_check = r_check ^ i_rx_byte;
                    n_seen  = seen_inc;
                    if ({3'b000, seen_inc} >= len_m1) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_SYNC1;
                    o_push  = 1'b1;
                    if (i_rx_byte != r_check) begin
                        o_desc.status = slxfp_pkg::STATUS_CHK_ERR;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == slxfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_len   <= '0;
            r_seen  <= '0;
            r_check <= '0;
            r_cmd   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_check <= n_check;
            r_cmd   <= n_cmd;
        end
    end

endmodule

/* design/slxfp_queue.sv */
module slxfp_queue #(
    parameter int DEPTH = slxfp_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  slxfp_pkg::t_frame_desc i_desc,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output slxfp_pkg::t_frame_desc o_desc
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    slxfp_pkg::t_frame_desc r_slot [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(do_push) - CntW'(do_pop);
        end
    end

endmodule

/* design/slxfp_back.sv */
`include "sync_length_xor_frame_parser_assert.svh"

module slxfp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  slxfp_pkg::t_store_wr   i_wr,
    input  logic                   i_q_empty,
    input  slxfp_pkg::t_frame_desc i_desc,
    output logic                   o_pop,
    output logic                   o_busy,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output logic [7:0]             o_command_code,
    output logic [7:0]             o_payload_byte,
    output logic [3:0]             o_payload_index,
    output logic                   o_has_payload,
    output logic                   o_last_of_frame,
    output logic [1:0]             o_frame_status
);

    localparam int StoreAw = slxfp_pkg::StoreAw;
    localparam int CountW  = slxfp_pkg::CountW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SINGLE = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_SEND   = 2'd3;

    logic [7:0]             r_store [slxfp_pkg::STORE_DEPTH];
    logic [7:0]             r_rd_data;
    logic [1:0]             r_state, n_state;
    logic [StoreAw-1:0]     r_idx, n_idx;
    slxfp_pkg::t_frame_desc r_desc, n_desc;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_cmd, n_cmd;
    logic [7:0]             r_byte, n_byte;
    logic [3:0]             r_index, n_index;
    logic                   r_has, n_has;
    logic                   r_last, n_last;
    logic [1:0]             r_status, n_status;
    logic                   out_free;
    logic                   is_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign out_free = !r_out_valid || i_res_ready;
    assign is_last  = ({1'b0, r_idx} + CountW'(1)) == r_desc.count;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_busy   = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_desc      = r_desc;
        n_out_valid = r_out_valid && !i_res_ready;
        n_cmd       = r_cmd;
        n_byte      = r_byte;
        n_index     = r_index;
        n_has       = r_has;
        n_last      = r_last;
        n_status    = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_desc = i_desc;
                    n_idx  = '0;
                    if (i_desc.status == slxfp_pkg::STATUS_OK && i_desc.count != '0) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_SINGLE;
                    end
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cmd       = r_desc.command;
                    n_byte      = 8'd0;
                    n_index     = 4'd0;
                    n_has       = 1'b0;
                    n_last      = 1'b1;
                    n_status    = r_desc.status;
                    n_state     = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cmd       = r_desc.command;
                    n_byte      = r_rd_data;
                    n_index     = 4'(r_idx);
                    n_has       = 1'b1;
                    n_last      = is_last;
                    n_status    = slxfp_pkg::STATUS_OK;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + StoreAw'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_desc   <= n_desc;
        r_cmd    <= n_cmd;
        r_byte   <= n_byte;
        r_index  <= n_index;
        r_has    <= n_has;
        r_last   <= n_last;
        r_status <= n_status;
    end

    assign o_res_valid     = r_out_valid;
    assign o_command_code  = r_cmd;
    assign o_payload_byte  = r_byte;
    assign o_payload_index = r_index;
    assign o_has_payload   = r_has;
    assign o_last_of_frame = r_last;
    assign o_frame_status  = r_status;

    `SLXFP_ASSERT_NOW(a_no_write_while_draining, i_clk, i_rst_n,
        i_wr.en, r_state == ST_IDLE && i_q_empty, "payload store written during drain")
    `SLXFP_ASSERT_NOW(a_index_in_frame, i_clk, i_rst_n,
        r_state == ST_SEND, ({1'b0, r_idx} < r_desc.count), "drain index beyond frame length")
    `SLXFP_ASSERT_NOW(a_payload_only_ok, i_clk, i_rst_n,
        r_out_valid && r_has, r_status == slxfp_pkg::STATUS_OK, "payload on error result")
    `SLXFP_ASSERT_NEXT(a_last_ends_drain, i_clk, i_rst_n,
        r_state == ST_SEND && out_free && is_last, r_state == ST_IDLE,
        "drain continues past last byte")

endmodule

/* design/sync_length_xor_frame_parser.sv */
// sync, length and xor-checksum frame parser
// input channel: one received byte per request on i_rx_valid / o_rx_ready
// the parser hunts for 0x06 0x85, takes a length, a command, the payload and
// an xor checksum seeded with the length
// output channel: one result per request on o_res_valid / i_res_ready; a good
// frame gives one result per payload byte (or one for a command-only frame),
// a bad checksum or an over-long length gives a single error result
// header bytes go at one per cycle, except that a length or closing byte waits
// while the frame queue is full; a good frame drains one payload byte at a time,
// each fetched from the payload store by a registered read; after the closing
// byte, a single result passes the queue, drain state and output register
// payload bytes of the next frame wait while an earlier frame is queued or
// draining; header bytes still go in, and a two-entry frame queue sits
// between the parser and the drain
// when the receiver stalls the output register holds and the queue fills,
// then the parser stops taking length and closing bytes
// reset clears the hunt state, the queue and the output register at once
module sync_length_xor_frame_parser #(
    parameter int MAX_PAYLOAD = slxfp_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = slxfp_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_command_code,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_payload_index,
    output logic       o_has_payload,
    output logic       o_last_of_frame,
    output logic [1:0] o_frame_status
);

    slxfp_pkg::t_drain_status drain;
    slxfp_pkg::t_frame_desc   push_desc;
    slxfp_pkg::t_frame_desc   head_desc;
    slxfp_pkg::t_store_wr     store_wr;
    logic                     push;
    logic                     pop;
    logic                     q_full;
    logic                     q_empty;
    logic                     back_busy;

    assign drain = '{q_full: q_full, pending: !q_empty || back_busy};

    slxfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_drain    (drain),
        .o_push     (push),
        .o_desc     (push_desc),
        .o_wr       (store_wr)
    );

    slxfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_desc  (head_desc)
    );

    slxfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (store_wr),
        .i_q_empty       (q_empty),
        .i_desc          (head_desc),
        .o_pop           (pop),
        .o_busy          (back_busy),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_command_code  (o_command_code),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_has_payload   (o_has_payload),
        .o_last_of_frame (o_last_of_frame),
        .o_frame_status  (o_frame_status)
    );

endmodule

/* test/sync_length_xor_frame_parser_check.sv */
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_command_code,
    input  logic [7:0] i_payload_byte,
    input  logic [3:0] i_payload_index,
    input  logic       i_has_payload,
    input  logic       i_last_of_frame,
    input  logic [1:0] i_frame_status,
    output int         o_fail_count,
    output int         o_outstanding
);

    localparam int CAPACITY = (slxfp_pkg::MAX_PAYLOAD_DEF < 1) ? 1 :
                              ((slxfp_pkg::MAX_PAYLOAD_DEF > slxfp_pkg::STORE_DEPTH) ?
                               slxfp_pkg::STORE_DEPTH : slxfp_pkg::MAX_PAYLOAD_DEF);
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_SYNC2    = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_COMMAND  = 3'd3,
        PH_PAYLOAD  = 3'd4,
        PH_CHECKSUM = 3'd5
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] data;
        logic [3:0] index;
        logic       has_data;
        logic       last;
        logic [1:0] status;
    } t_frame_result;

    t_parse_phase  phase = PH_HUNT;
    logic [7:0]    frame_len = 8'd0;
    logic [7:0]    payload_count = 8'd0;
    logic [7:0]    xor_sum = 8'd0;
    logic [7:0]    command_held = 8'd0;
    logic [7:0]    payload_buf [slxfp_pkg::STORE_DEPTH];
    t_frame_result pending_results [$];
    int            fail_total = 0;

    task automatic add_result(input logic [7:0] command, input logic [7:0] data,
                              input logic [3:0] index, input logic has_data,
                              input logic last, input logic [1:0] status);
        t_frame_result r;
        r.command  = command;
        r.data     = data;
        r.index    = index;
        r.has_data = has_data;
        r.last     = last;
        r.status   = status;
        pending_results = {pending_results, r};
    endtask

    task automatic parse_rx_byte(input logic [7:0] value);
        int count;
        int i;
        case (phase)
            PH_SYNC2: begin
                if (value == slxfp_pkg::SYNC_SECOND) begin
                    phase = PH_LENGTH;
                end else begin
                    phase = (value == slxfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            end
            PH_LENGTH: begin
                if (value == 8'd0) begin
                    phase = PH_HUNT;
                end else if (int'(value) - 1 > CAPACITY) begin
                    phase = PH_HUNT;
                    add_result(8'd0, 8'd0, 4'd0, 1'b0, 1'b1, slxfp_pkg::STATUS_LEN_ERR);
                end else begin
                    frame_len     = value;
                    xor_sum       = value;
                    payload_count = 8'd0;
                    phase         = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                command_held = value;
                xor_sum      = xor_sum ^ value;
                phase        = (frame_len > 8'd1) ? PH_PAYLOAD : PH_CHECKSUM;
            end
            PH_PAYLOAD: begin
                payload_buf[payload_count[slxfp_pkg::StoreAw-1:0]] = value;
                xor_sum       = xor_sum ^ value;
                payload_count = payload_count + 8'd1;
                if (int'(payload_count) >= int'(frame_len) - 1) begin
                    phase = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM: begin
                phase = PH_HUNT;
                if (value != xor_sum) begin
                    add_result(command_held, 8'd0, 4'd0, 1'b0, 1'b1,
                               slxfp_pkg::STATUS_CHK_ERR);
                end else begin
                    count = int'(frame_len) - 1;
                    if (count > slxfp_pkg::STORE_DEPTH) begin
                        count = slxfp_pkg::STORE_DEPTH;
                    end
                    if (count == 0) begin
                        add_result(command_held, 8'd0, 4'd0, 1'b0, 1'b1,
                                   slxfp_pkg::STATUS_OK);
                    end else begin
                        for (i = 0; i < count; i++) begin
                            add_result(command_held, payload_buf[i], i[3:0], 1'b1,
                                       (i == count - 1), slxfp_pkg::STATUS_OK);
                        end
                    end
                end
            end
            default: begin
                phase = (value == slxfp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    endtask

    task automatic check_result();
        t_frame_result got;
        t_frame_result want;
        got.command  = i_command_code;
        got.data     = i_payload_byte;
        got.index    = i_payload_index;
        got.has_data = i_has_payload;
        got.last     = i_last_of_frame;
        got.status   = i_frame_status;
        if (pending_results.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
                $display("%0t: unexpected: cmd %h data %h idx %0d has %b last %b st %0d",
                         $realtime, got.command, got.data, got.index, got.has_data, got.last,
                         got.status);
            end
        end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT) begin
                    $display("%0t: expected cmd %h data %h idx %0d has %b last %b st %0d",
                             $realtime, want.command, want.data, want.index, want.has_data,
                             want.last, want.status);
                    $display("%0t: actual   cmd %h data %h idx %0d has %b last %b st %0d",
                             $realtime, got.command, got.data, got.index, got.has_data,
                             got.last, got.status);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase         = PH_HUNT;
            frame_len     = 8'd0;
            payload_count = 8'd0;
            xor_sum       = 8'd0;
            command_held  = 8'd0;
            pending_results.delete();
        end else begin
            if (i_rx_valid && i_rx_ready) begin
                parse_rx_byte(i_rx_byte);
            end
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
        end
        o_outstanding <= pending_results.size();
        o_fail_count  <= fail_total;
    end

endmodule

/* test/sync_length_xor_frame_parser_test.sv */
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_test;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int TARGET_BYTES = 120;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int DRAIN_FRAME  = 10;

    typedef enum logic [1:0] {
        SINK_STEADY,
        SINK_RANDOM,
        SINK_STALLS
    } t_sink_mode;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic [7:0] rx_byte = 8'd0;
    logic       res_ready = 1'b0;
    logic       rx_ready;
    logic       res_valid;
    logic [7:0] command_code;
    logic [7:0] payload_byte;
    logic [3:0] payload_index;
    logic       has_payload;
    logic       last_of_frame;
    logic [1:0] frame_status;
    int         fail_count;
    int         outstanding;

    int         burst_left = 0;
    int         idle_cycles = 0;
    int         frame_bytes = 0;
    int         frames_sent = 0;
    t_sink_mode sink_mode = SINK_STEADY;
    int         mode_cycles = 0;
    int         stall_left = 0;
    logic       ready_next;

    always #HALF_PERIOD clk = ~clk;

    sync_length_xor_frame_parser uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_command_code  (command_code),
        .o_payload_byte  (payload_byte),
        .o_payload_index (payload_index),
        .o_has_payload   (has_payload),
        .o_last_of_frame (last_of_frame),
        .o_frame_status  (frame_status)
    );

    sync_length_xor_frame_parser_check frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_rx_valid      (rx_valid),
        .i_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_command_code  (command_code),
        .i_payload_byte  (payload_byte),
        .i_payload_index (payload_index),
        .i_has_payload   (has_payload),
        .i_last_of_frame (last_of_frame),
        .i_frame_status  (frame_status),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // receiver back-pressure in a steady, random or stalling mode picked at random
    always @(posedge clk) begin
        if (mode_cycles == 0) begin
            sink_mode   = t_sink_mode'($urandom_range(0, 2));
            mode_cycles = $urandom_range(20, 80);
        end else begin
            mode_cycles--;
        end
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            case (sink_mode)
                SINK_STEADY: ready_next = 1'b1;
                SINK_RANDOM: ready_next = 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(5, 40);
                        ready_next = 1'b0;
                    end else begin
                        ready_next = 1'b1;
                    end
                end
            endcase
        end
        res_ready <= ready_next;
    end

    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        burst_left--;
        frame_bytes++;
    endtask

    task automatic wait_drained();
        rx_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic send_random_frame();
        int         kind;
        int         pick;
        int         i;
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] value;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = 8'($urandom_range(1, 5));
            end else if (pick < 8) begin
                len = 8'($urandom_range(6, 16));
            end else begin
                len = 8'd17;
            end
            cmd = 8'($urandom);
            sum = len ^ cmd;
            send_byte(slxfp_pkg::SYNC_FIRST);
            send_byte(slxfp_pkg::SYNC_SECOND);
            send_byte(len);
            send_byte(cmd);
            for (i = 1; i < int'(len); i++) begin
                value = 8'($urandom);
                sum   = sum ^ value;
                send_byte(value);
            end
            if ($urandom_range(0, 6) == 0) begin
                sum = sum ^ (8'd1 << $urandom_range(0, 7));
            end
            send_byte(sum);
        end else if (kind < 80) begin
            // length beyond capacity
            len = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(18, 255));
            send_byte(slxfp_pkg::SYNC_FIRST);
            send_byte(slxfp_pkg::SYNC_SECOND);
            send_byte(len);
        end else if (kind < 85) begin
            send_byte(slxfp_pkg::SYNC_FIRST);
            send_byte(slxfp_pkg::SYNC_SECOND);
            send_byte(8'd0);
        end else if (kind < 92) begin
            value = 8'($urandom);
            if (value == slxfp_pkg::SYNC_SECOND) begin
                value = value ^ 8'h01;
            end
            send_byte(slxfp_pkg::SYNC_FIRST);
            send_byte(value);
        end else begin
            pick = $urandom_range(1, 4);
            for (i = 0; i < pick; i++) begin
                value = ($urandom_range(0, 4) == 0) ? slxfp_pkg::SYNC_FIRST : 8'($urandom);
                send_byte(value);
            end
        end
        frames_sent++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // noise, wrong second sync, repeated first sync, then zero length
        send_byte(8'h00); send_byte(slxfp_pkg::SYNC_FIRST); send_byte(8'h84);
        send_byte(8'hFF); send_byte(slxfp_pkg::SYNC_FIRST);
        send_byte(slxfp_pkg::SYNC_FIRST); send_byte(slxfp_pkg::SYNC_SECOND);
        send_byte(8'h00);
        // length one past capacity
        send_byte(slxfp_pkg::SYNC_FIRST); send_byte(slxfp_pkg::SYNC_SECOND);
        send_byte(8'h12);
        // command-only frame
        send_byte(slxfp_pkg::SYNC_FIRST); send_byte(slxfp_pkg::SYNC_SECOND);
        send_byte(8'h01); send_byte(8'hFF); send_byte(8'hFE);
        // bad checksum
        send_byte(slxfp_pkg::SYNC_FIRST); send_byte(slxfp_pkg::SYNC_SECOND);
        send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
        // two payload bytes
        send_byte(slxfp_pkg::SYNC_FIRST); send_byte(slxfp_pkg::SYNC_SECOND);
        send_byte(8'h03); send_byte(8'hA5); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'h59);
        wait_drained();

        while (frame_bytes < TARGET_BYTES) begin
            send_random_frame();
            if (frames_sent == DRAIN_FRAME) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
